// ===== rtl/serial_keypad_display_link_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the serial keypad/display link
// Shared clocked assertion forms, reset-qualified, reporting by $error.
// ----------------------------------------------------------------------------
`ifndef SERIAL_KEYPAD_DISPLAY_LINK_ASSERT_SVH
`define SERIAL_KEYPAD_DISPLAY_LINK_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define SKDL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define SKDL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/skdl_pkg.sv =====
// ----------------------------------------------------------------------------
// skdl_pkg
// Types, constants and the segment table of the serial keypad/display link.
// ----------------------------------------------------------------------------
package skdl_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int ADDR_W      = 5;
    localparam int MAX_BEATS   = 8;
    localparam int IDX_W       = $clog2(MAX_BEATS);
    localparam int BEATS_W     = $clog2(MAX_BEATS + 1);

    typedef logic [BEATS_W-1:0] t_beats;

    localparam t_beats BEATS_NONE  = t_beats'(0);
    localparam t_beats BEATS_INIT  = t_beats'(2);
    localparam t_beats BEATS_FRAME = t_beats'(6);
    localparam t_beats BEATS_RESET = t_beats'(8);

    localparam logic [7:0] ACK_CODE_RST     = 8'h40;
    localparam logic [7:0] BTN_EVENT_RST    = 8'h41;
    localparam logic [7:0] DEV_RESET_RST    = 8'h42;
    localparam logic [7:0] LED_SET_RST      = 8'hC6;
    localparam logic [7:0] LED_USER_RST     = 8'hC5;
    localparam logic [7:0] BTN_IRQ_ON_RST   = 8'hC3;

    localparam logic [7:0] FRAME_SECOND     = 8'h0F;
    localparam logic [7:0] DOT_BIT          = 8'h10;
    localparam logic [7:0] BUTTONS_RELEASED = 8'hFF;

    typedef enum logic [1:0] {
        ACT_PACKET  = 2'd0,
        ACT_INIT    = 2'd1,
        ACT_DISPLAY = 2'd2,
        ACT_READ    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        REG_ACK_CODE   = 3'd0,
        REG_BTN_EVENT  = 3'd1,
        REG_DEV_RESET  = 3'd2,
        REG_LED_SET    = 3'd3,
        REG_LED_USER   = 3'd4,
        REG_BTN_IRQ_ON = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] ack_code;
        logic [7:0] button_event_code;
        logic [7:0] device_reset_code;
        logic [7:0] led_set_command;
        logic [7:0] led_user_mode_command;
        logic [7:0] button_irq_on_command;
    } t_cfg;

    // One queued job: the bytes to send in order, how many, and side info.
    typedef struct packed {
        logic [MAX_BEATS-1:0][7:0] data;
        t_beats                    beats;
        logic [7:0]                buttons;
        logic                      status;
    } t_job;

    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        case (digit)
            4'h0:    pat = 8'hE7;
            4'h1:    pat = 8'h06;
            4'h2:    pat = 8'hCB;
            4'h3:    pat = 8'h8F;
            4'h4:    pat = 8'h2E;
            4'h5:    pat = 8'hAD;
            4'h6:    pat = 8'hED;
            4'h7:    pat = 8'h86;
            4'h8:    pat = 8'hEF;
            4'h9:    pat = 8'hAE;
            4'hA:    pat = 8'hEE;
            4'hB:    pat = 8'h6D;
            4'hC:    pat = 8'hE1;
            4'hD:    pat = 8'h4F;
            4'hE:    pat = 8'hE9;
            default: pat = 8'hE8;
        endcase
        return pat;
    endfunction

endpackage

// ===== rtl/skdl_in_if.sv =====
// ----------------------------------------------------------------------------
// skdl_in_if
// Command channel: valid/ready plus one action and its operands.
// ----------------------------------------------------------------------------
interface skdl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  packet_opcode;
    logic [7:0]  packet_byte1;
    logic [7:0]  packet_byte2;
    logic [15:0] digit_values;
    logic [3:0]  digit_enables;
    logic [3:0]  dot_enables;

    modport source (
        output valid, action, packet_opcode, packet_byte1, packet_byte2,
               digit_values, digit_enables, dot_enables,
        input  ready
    );
    modport sink (
        input  valid, action, packet_opcode, packet_byte1, packet_byte2,
               digit_values, digit_enables, dot_enables,
        output ready
    );
endinterface

// ===== rtl/skdl_out_if.sv =====
// ----------------------------------------------------------------------------
// skdl_out_if
// Result channel: valid/ready plus one transmit beat.
// ----------------------------------------------------------------------------
interface skdl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       last;
    logic [7:0] buttons;
    logic       status;

    modport source (
        output valid, tx_byte, tx_valid, last, buttons, status,
        input  ready
    );
    modport sink (
        input  valid, tx_byte, tx_valid, last, buttons, status,
        output ready
    );
endinterface

// ===== rtl/skdl_front.sv =====
// ----------------------------------------------------------------------------
// skdl_front
// Accept commands, update link state, and queue the bytes each one sends.
// ----------------------------------------------------------------------------
module skdl_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    skdl_in_if.sink            i_cmd,
    input  skdl_pkg::t_cfg     i_cfg,
    input  logic               i_q_ready,
    output logic               o_push,
    output skdl_pkg::t_job     o_job
);

    logic                r_ack;
    logic                n_ack;
    logic [7:0]          r_buttons;
    logic [7:0]          n_buttons;
    logic [5:0][7:0]     r_frame;
    logic [5:0][7:0]     n_frame;
    logic [5:0][7:0]     disp_frame;
    logic [7:0]          evt_buttons;
    skdl_pkg::t_job      job;

    assign i_cmd.ready = i_q_ready;
    assign o_push      = i_cmd.valid && i_q_ready;

    // Buttons in the low nibble, directions above with their middle bits swapped.
    assign evt_buttons = {i_cmd.packet_byte2[3], i_cmd.packet_byte2[1],
                          i_cmd.packet_byte2[2], i_cmd.packet_byte2[0],
                          i_cmd.packet_byte1[3:0]};

    always_comb begin
        disp_frame[0] = i_cfg.led_set_command;
        disp_frame[1] = skdl_pkg::FRAME_SECOND;
        for (int k = 0; k < 4; k++) begin
            disp_frame[k+2] = i_cmd.digit_enables[k]
                            ? skdl_pkg::seg_pattern(i_cmd.digit_values[4*k +: 4])
                            : 8'h00;
            if (i_cmd.dot_enables[k]) begin
                disp_frame[k+2] = disp_frame[k+2] | skdl_pkg::DOT_BIT;
            end
        end
    end

    always_comb begin
        n_ack     = r_ack;
        n_buttons = r_buttons;
        n_frame   = r_frame;
        job       = '0;
        unique case (skdl_pkg::t_action'(i_cmd.action))
            skdl_pkg::ACT_PACKET: begin
                if (i_cmd.packet_opcode == i_cfg.ack_code) begin
                    n_ack = 1'b1;
                end else if (i_cmd.packet_opcode == i_cfg.button_event_code) begin
                    n_buttons = evt_buttons;
                end else if (i_cmd.packet_opcode == i_cfg.device_reset_code) begin
                    n_ack       = 1'b1;
                    n_buttons   = skdl_pkg::BUTTONS_RELEASED;
                    job.data[0] = i_cfg.led_user_mode_command;
                    job.data[1] = i_cfg.button_irq_on_command;
                    for (int k = 0; k < 6; k++) begin
                        job.data[k+2] = r_frame[k];
                    end
                    job.beats = skdl_pkg::BEATS_RESET;
                end
            end
            skdl_pkg::ACT_INIT: begin
                n_ack       = 1'b1;
                n_buttons   = skdl_pkg::BUTTONS_RELEASED;
                job.data[0] = i_cfg.led_user_mode_command;
                job.data[1] = i_cfg.button_irq_on_command;
                job.beats   = skdl_pkg::BEATS_INIT;
            end
            skdl_pkg::ACT_DISPLAY: begin
                if (r_ack) begin
                    n_ack   = 1'b0;
                    n_frame = disp_frame;
                    for (int k = 0; k < 6; k++) begin
                        job.data[k] = disp_frame[k];
                    end
                    job.beats = skdl_pkg::BEATS_FRAME;
                end else begin
                    job.status = 1'b1;
                end
            end
            skdl_pkg::ACT_READ: begin
                job.beats = skdl_pkg::BEATS_NONE;
            end
            default: begin
                job.beats = skdl_pkg::BEATS_NONE;
            end
        endcase
        job.buttons = n_buttons;
    end

    assign o_job = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack     <= 1'b0;
            r_buttons <= 8'h00;
            r_frame   <= '0;
        end else if (o_push) begin
            r_ack     <= n_ack;
            r_buttons <= n_buttons;
            r_frame   <= n_frame;
        end
    end

endmodule

// ===== rtl/skdl_queue.sv =====
// ----------------------------------------------------------------------------
// skdl_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
`include "serial_keypad_display_link_assert.svh"

module skdl_queue #(
    parameter int DEPTH = skdl_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  skdl_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_ready,
    output logic           o_head_valid,
    output skdl_pkg::t_job o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    skdl_pkg::t_job   r_q [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push_ok;

    assign o_ready      = (r_count < CNT_W'(DEPTH));
    assign push_ok      = i_push && o_ready;
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push_ok && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `SKDL_ASSERT(a_count_bound, i_clk, i_rst_n, (r_count <= CNT_W'(DEPTH)), "queue overfilled")
    `SKDL_ASSERT(a_pop_nonempty, i_clk, i_rst_n, (i_pop |-> r_count != '0), "pop of empty queue")
    `SKDL_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, (push_ok && !i_pop), (r_count == $past(r_count) + CNT_W'(1)), "queue count did not grow on push")

endmodule

// ===== rtl/skdl_back.sv =====
// ----------------------------------------------------------------------------
// skdl_back
// Step through the head job into the output register, one beat per cycle while the output is taken.
// ----------------------------------------------------------------------------
module skdl_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  skdl_pkg::t_job i_head,
    output logic           o_pop,
    skdl_out_if.source     o_rsp
);

    logic [skdl_pkg::IDX_W-1:0] r_idx;
    logic                       r_valid;
    logic [7:0]                 r_tx_byte;
    logic                       r_tx_valid;
    logic                       r_last;
    logic [7:0]                 r_buttons;
    logic                       r_status;
    logic                       load;
    logic                       beat_last;
    logic                       has_bytes;

    assign has_bytes = (i_head.beats != skdl_pkg::BEATS_NONE);
    assign beat_last = !has_bytes
                    || ({1'b0, r_idx} == skdl_pkg::BEATS_W'(i_head.beats - 1'b1));
    assign load      = i_head_valid && (!r_valid || o_rsp.ready);
    assign o_pop     = load && beat_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= beat_last ? '0 : r_idx + 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tx_byte  <= has_bytes ? i_head.data[r_idx] : 8'h00;
            r_tx_valid <= has_bytes;
            r_last     <= beat_last;
            r_buttons  <= i_head.buttons;
            r_status   <= i_head.status;
        end
    end

    assign o_rsp.valid    = r_valid;
    assign o_rsp.tx_byte  = r_tx_byte;
    assign o_rsp.tx_valid = r_tx_valid;
    assign o_rsp.last     = r_last;
    assign o_rsp.buttons  = r_buttons;
    assign o_rsp.status   = r_status;

endmodule

// ===== rtl/serial_keypad_display_link.sv =====
// A command's job is registered in the queue, then its first beat in the output register.
// Throughput: one beat per cycle while the output is taken. A command sends one beat
//   per byte, or one empty beat for packets, reads and dropped updates: two for init,
//   six for a display frame, eight for a device reset. The front end sets that figure.
// Reset (synchronous, active low) clears the ack flag, button byte, saved frame,
//   queue and output valid flag, and loads the register defaults. No clearing pass.
// ----------------------------------------------------------------------------
// serial_keypad_display_link
// Host side of a serial keypad/display controller with an APB register port.
// ----------------------------------------------------------------------------
module serial_keypad_display_link #(
    parameter int QUEUE_DEPTH = skdl_pkg::QUEUE_DEPTH  // two or more
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    skdl_in_if.sink                     i_cmd,
    skdl_out_if.source                  o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [skdl_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    skdl_pkg::t_cfg r_cfg;
    logic           cfg_wr;
    logic           q_ready;
    logic           push;
    logic           pop;
    logic           head_valid;
    skdl_pkg::t_job push_job;
    skdl_pkg::t_job head_job;
    logic [7:0]     rd_byte;

    // Register port: no wait states, word-addressed registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ack_code              <= skdl_pkg::ACK_CODE_RST;
            r_cfg.button_event_code     <= skdl_pkg::BTN_EVENT_RST;
            r_cfg.device_reset_code     <= skdl_pkg::DEV_RESET_RST;
            r_cfg.led_set_command       <= skdl_pkg::LED_SET_RST;
            r_cfg.led_user_mode_command <= skdl_pkg::LED_USER_RST;
            r_cfg.button_irq_on_command <= skdl_pkg::BTN_IRQ_ON_RST;
        end else if (cfg_wr) begin
            // Drop writes to unmapped words.
            unique case (skdl_pkg::t_reg_idx'(paddr[4:2]))
                skdl_pkg::REG_ACK_CODE:   r_cfg.ack_code              <= pwdata[7:0];
                skdl_pkg::REG_BTN_EVENT:  r_cfg.button_event_code     <= pwdata[7:0];
                skdl_pkg::REG_DEV_RESET:  r_cfg.device_reset_code     <= pwdata[7:0];
                skdl_pkg::REG_LED_SET:    r_cfg.led_set_command       <= pwdata[7:0];
                skdl_pkg::REG_LED_USER:   r_cfg.led_user_mode_command <= pwdata[7:0];
                skdl_pkg::REG_BTN_IRQ_ON: r_cfg.button_irq_on_command <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (skdl_pkg::t_reg_idx'(paddr[4:2]))
            skdl_pkg::REG_ACK_CODE:   rd_byte = r_cfg.ack_code;
            skdl_pkg::REG_BTN_EVENT:  rd_byte = r_cfg.button_event_code;
            skdl_pkg::REG_DEV_RESET:  rd_byte = r_cfg.device_reset_code;
            skdl_pkg::REG_LED_SET:    rd_byte = r_cfg.led_set_command;
            skdl_pkg::REG_LED_USER:   rd_byte = r_cfg.led_user_mode_command;
            skdl_pkg::REG_BTN_IRQ_ON: rd_byte = r_cfg.button_irq_on_command;
            default:                  rd_byte = 8'h00;
        endcase
    end

    assign prdata = {24'h000000, rd_byte};

    // Front end: take a command beat, update link state, build its job.
    skdl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .i_cfg     (r_cfg),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_job     (push_job)
    );

    // Queue: lets the front keep accepting while the back is stalled.
    skdl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (push_job),
        .i_pop        (pop),
        .o_ready      (q_ready),
        .o_head_valid (head_valid),
        .o_head       (head_job)
    );

    // Back end: advance through the head job one result beat per cycle while the output is taken.
    skdl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_job),
        .o_pop        (pop),
        .o_rsp        (o_rsp)
    );

endmodule
